// ===== hw/rtl/wis_pkg.sv =====
// Shared types, constants and helper functions for the warp issue scheduler.
// No dependencies; the datapath, controller, top level, checker and testbench top import this package.
package wis_pkg;

   localparam int WARPS     = 32;
   localparam int WIDX      = 5;
   localparam int CNT_W     = 6;
   localparam int MAX_SLICE = 16;

   localparam logic [63:0] GAMMA = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_C1 = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_C2 = 64'h94D0_49BB_1331_11EB;

   // register indexes
   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_SEED  = 2'd1;
   localparam logic [1:0] REG_SLICE = 2'd2;

   // mode codes; the unused code runs as round robin
   localparam logic [1:0] MODE_RR   = 2'd0;
   localparam logic [1:0] MODE_RAND = 2'd1;
   localparam logic [1:0] MODE_OLD  = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_FIN_SLICE, OP_FIN_RSLICE, OP_FIN_EMPTY, OP_FIN_RR,
      OP_FIN_RAND, OP_OSTART, OP_OSTEP, OP_ONEXT, OP_OTIE, OP_OFIN, OP_RSTART,
      OP_RSTEP, OP_REM_MAX, OP_REM_V, OP_REM_STEP, OP_LIM, OP_ADV, OP_MUL,
      OP_MIX2, OP_MIX3, OP_KSET, OP_KZERO, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [1:0]       phase;
      logic             adv;
      logic             n_load;
      logic [CNT_W-1:0] n_val;
   } cmd_type;

   typedef struct packed {
      logic             kind;
      logic [1:0]       mode;
      logic [CNT_W-1:0] count;
      logic             n_le1;
      logic             v_gt_lim;
      logic             bit_on;
      logic             idx_last;
      logic             cand;
      logic             t_lt;
      logic             t_eq;
      logic             kth_hit;
      logic             out_free;
   } stat_type;

   function automatic logic [CNT_W-1:0] popcount(input logic [WARPS-1:0] m);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < WARPS; i++) c = c + CNT_W'(m[i]);
      return c;
   endfunction

   function automatic logic [WIDX-1:0] lowest(input logic [WARPS-1:0] m);
      logic [WIDX-1:0] r;
      r = '0;
      for (int i = WARPS - 1; i >= 0; i--) if (m[i]) r = WIDX'(i);
      return r;
   endfunction

endpackage

// ===== hw/rtl/wis_ifs.sv =====
// Channel interfaces of the warp issue scheduler: request, response, register write.
// Depends on nothing; widths follow the item fields.
interface wis_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] runnable_mask;
   modport source (output valid, kind, runnable_mask, input ready);
   modport sink (input valid, kind, runnable_mask, output ready);
endinterface

interface wis_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] picked_warp;
   logic [7:0] slice_length;
   logic       no_runnable;
   modport source (output valid, picked_warp, slice_length, no_runnable, input ready);
   modport sink (input valid, picked_warp, slice_length, no_runnable, output ready);
endinterface

interface wis_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/wis_datapath.sv =====
// Datapath: registers, generator, shared 32x32 multiplier, remainder unit,
// last-run table and result register. Depends on wis_pkg and wis_ifs.
module wis_datapath (
   input  logic             clock,
   input  logic             reset,
   input  wis_pkg::cmd_type cmd,
   input  logic             req_ready,
   output wis_pkg::stat_type stat,
   wis_req_if.sink          req_chan,
   wis_rsp_if.source        rsp_chan,
   wis_csr_if.sink          csr_chan
);
   import wis_pkg::*;

   logic [1:0]        mode_ff;
   logic [63:0]       seed_ff;
   logic [7:0]        dslice_ff;
   logic [63:0]       rng_ff;
   logic [WIDX-1:0]   last_ff;
   logic              have_last_ff;
   logic [63:0]       tick_ff;
   logic [63:0]       tbl_ff [WARPS];
   logic [WARPS-1:0]  tvld_ff;

   logic              kind_ff;
   logic [WARPS-1:0]  mask_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [63:0]       za_ff, acc_ff, v_ff, lim_ff, div_ff;
   logic              csel_ff;
   logic [CNT_W-1:0]  n_ff, rem_ff, k_ff, seen_ff;
   logic [WIDX-1:0]   idx_ff, best_ff;
   logic              best_none_ff;
   logic [63:0]       oldest_ff;

   logic [WIDX-1:0]   res_pick_ff;
   logic [7:0]        res_slice_ff;
   logic              res_empty_ff;
   logic              rsp_valid_ff;
   logic [WIDX-1:0]   out_pick_ff;
   logic [7:0]        out_slice_ff;
   logic              out_empty_ff;

   logic [63:0]       t_cur, s_adv, mconst, prod;
   logic [31:0]       a_part, b_part;
   logic [CNT_W-1:0]  rem_in;
   logic [WARPS-1:0]  above;
   logic [WIDX-1:0]   rr_pick;
   logic              cand, t_lt, t_eq, out_free;

   // read the last-run entry under the scan index; an unwritten entry reads zero
   assign t_cur = tvld_ff[idx_ff] ? tbl_ff[idx_ff] : 64'd0;
   assign t_lt  = t_cur < oldest_ff;
   assign t_eq  = t_cur == oldest_ff;
   assign cand  = !(have_last_ff && (idx_ff == last_ff) && (count_ff > CNT_W'(1)));

   // one 32x32 partial product per cycle of the 64-bit low product
   assign mconst = csel_ff ? MIX_C2 : MIX_C1;
   assign a_part = (cmd.phase == 2'd2) ? za_ff[63:32] : za_ff[31:0];
   assign b_part = (cmd.phase == 2'd1) ? mconst[63:32] : mconst[31:0];
   assign prod   = 64'(a_part) * 64'(b_part);
   assign s_adv  = rng_ff + GAMMA;

   // four restoring remainder steps per cycle
   always_comb begin
      logic [CNT_W:0] r;
      rem_in = rem_ff;
      for (int j = 0; j < 4; j++) begin
         r = {rem_in, div_ff[63-j]};
         if (r >= {1'b0, n_ff}) r = r - {1'b0, n_ff};
         rem_in = r[CNT_W-1:0];
      end
   end

   // round robin: lowest runnable above the last pick, else the lowest
   always_comb begin
      for (int i = 0; i < WARPS; i++) above[i] = mask_ff[i] && (WIDX'(i) > last_ff);
      rr_pick = (have_last_ff && (|above)) ? lowest(above) : lowest(mask_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      stat.kind     = kind_ff;
      stat.mode     = mode_ff;
      stat.count    = count_ff;
      stat.n_le1    = n_ff <= CNT_W'(1);
      stat.v_gt_lim = v_ff > lim_ff;
      stat.bit_on   = mask_ff[idx_ff];
      stat.idx_last = idx_ff == WIDX'(WARPS - 1);
      stat.cand     = cand;
      stat.t_lt     = t_lt;
      stat.t_eq     = t_eq;
      stat.kth_hit  = mask_ff[idx_ff] && (seen_ff == k_ff);
      stat.out_free = out_free;
   end

   assign csr_chan.ready     = 1'b1;
   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.picked_warp  = out_pick_ff;
   assign rsp_chan.slice_length = out_slice_ff;
   assign rsp_chan.no_runnable  = out_empty_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_RR;
         seed_ff      <= 64'd1;
         dslice_ff    <= 8'd1;
         rng_ff       <= 64'd1;
         last_ff      <= '0;
         have_last_ff <= 1'b0;
         tick_ff      <= '0;
         tvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once transferred, load a fresh one on emit
         if (cmd.op == OP_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;

         if (cmd.op == OP_ADV) rng_ff <= s_adv;
         if (cmd.op == OP_FIN_RR) begin
            last_ff      <= rr_pick;
            have_last_ff <= 1'b1;
         end
         if (cmd.op == OP_OSTART) tick_ff <= tick_ff + 64'd1;
         if (cmd.op == OP_OFIN) begin
            last_ff          <= best_ff;
            have_last_ff     <= 1'b1;
            tvld_ff[best_ff] <= 1'b1;
         end

         // the user must write registers only while idle; the block itself does not enforce it
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               REG_MODE: begin
                  mode_ff      <= csr_chan.data[1:0];
                  rng_ff       <= (seed_ff == 64'd0) ? 64'd1 : seed_ff;
                  last_ff      <= '0;
                  have_last_ff <= 1'b0;
                  tick_ff      <= '0;
                  tvld_ff      <= '0;
               end
               REG_SEED: begin
                  seed_ff <= csr_chan.data;
                  rng_ff  <= (csr_chan.data == 64'd0) ? 64'd1 : csr_chan.data;
               end
               REG_SLICE: dslice_ff <= csr_chan.data[7:0];
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.n_load) n_ff <= cmd.n_val;
      if (cmd.op == OP_OFIN) tbl_ff[best_ff] <= tick_ff;
      if (cmd.op == OP_EMIT) begin
         out_pick_ff  <= res_pick_ff;
         out_slice_ff <= res_slice_ff;
         out_empty_ff <= res_empty_ff;
      end
      unique case (cmd.op)
         OP_ACCEPT: begin
            kind_ff  <= req_chan.kind;
            mask_ff  <= req_chan.runnable_mask;
            count_ff <= popcount(req_chan.runnable_mask);
         end
         OP_FIN_SLICE: begin
            res_pick_ff  <= '0;
            res_slice_ff <= (mode_ff == MODE_OLD) ? 8'd1 : dslice_ff;
            res_empty_ff <= 1'b0;
         end
         OP_FIN_RSLICE: begin
            res_pick_ff  <= '0;
            res_slice_ff <= 8'(k_ff) + 8'd1;
            res_empty_ff <= 1'b0;
         end
         OP_FIN_EMPTY: begin
            res_pick_ff  <= '0;
            res_slice_ff <= '0;
            res_empty_ff <= 1'b1;
         end
         OP_FIN_RR: begin
            res_pick_ff  <= rr_pick;
            res_slice_ff <= '0;
            res_empty_ff <= 1'b0;
         end
         OP_FIN_RAND: begin
            res_pick_ff  <= idx_ff;
            res_slice_ff <= '0;
            res_empty_ff <= 1'b0;
         end
         OP_OFIN: begin
            res_pick_ff  <= best_ff;
            res_slice_ff <= '0;
            res_empty_ff <= 1'b0;
         end
         OP_OSTART: begin
            idx_ff       <= '0;
            best_ff      <= '0;
            best_none_ff <= 1'b1;
            oldest_ff    <= '1;
         end
         OP_OSTEP: begin
            if (best_none_ff) begin
               best_ff      <= idx_ff;
               best_none_ff <= 1'b0;
            end
            if (cand && t_lt) begin
               best_ff   <= idx_ff;
               oldest_ff <= t_cur;
            end
            if (cmd.adv) idx_ff <= idx_ff + WIDX'(1);
         end
         OP_ONEXT: idx_ff <= idx_ff + WIDX'(1);
         OP_OTIE: begin
            if (k_ff != '0) begin
               best_ff   <= idx_ff;
               oldest_ff <= t_cur;
            end
            idx_ff <= idx_ff + WIDX'(1);
         end
         OP_RSTART: begin
            idx_ff  <= '0;
            seen_ff <= '0;
         end
         OP_RSTEP: begin
            if (mask_ff[idx_ff]) seen_ff <= seen_ff + CNT_W'(1);
            idx_ff <= idx_ff + WIDX'(1);
         end
         OP_REM_MAX: begin
            div_ff <= '1;
            rem_ff <= '0;
         end
         OP_REM_V: begin
            div_ff <= v_ff;
            rem_ff <= '0;
         end
         OP_REM_STEP: begin
            div_ff <= {div_ff[59:0], 4'b0};
            rem_ff <= rem_in;
         end
         OP_LIM: lim_ff <= ~(64'(rem_ff)) - 64'd1;
         OP_ADV: begin
            za_ff   <= s_adv ^ (s_adv >> 30);
            csel_ff <= 1'b0;
         end
         OP_MUL: begin
            if (cmd.phase == 2'd0) acc_ff <= prod;
            else acc_ff <= acc_ff + {prod[31:0], 32'd0};
         end
         OP_MIX2: begin
            za_ff   <= acc_ff ^ (acc_ff >> 27);
            csel_ff <= 1'b1;
         end
         OP_MIX3: v_ff <= acc_ff ^ (acc_ff >> 31);
         OP_KSET: k_ff <= rem_ff;
         OP_KZERO: k_ff <= '0;
         default: ;
      endcase
   end

endmodule

// ===== hw/rtl/wis_ctrl.sv =====
// Controller state machine: sequences acceptance, draws, scans and emit.
// Depends on wis_pkg; drives the datapath through cmd_type, reads stat_type.
module wis_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wis_pkg::stat_type stat,
   output wis_pkg::cmd_type  cmd
);
   import wis_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_BELOW, S_LREM, S_LIM, S_ADV, S_M1, S_X2, S_M2, S_X3,
      S_CHK, S_VREM, S_KSET, S_RET, S_RSCAN, S_OSCAN, S_OFIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {R_SLICE, R_RAND, R_TIE} ret_type;

   state_type  state_ff, state_in;
   ret_type    ret_ff, ret_in;
   logic [3:0] cnt_ff, cnt_in;

   always_comb begin
      cmd       = '{op: OP_NONE, phase: cnt_ff[1:0], adv: 1'b0, n_load: 1'b0,
                    n_val: '0};
      state_in  = state_ff;
      ret_in    = ret_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (stat.kind) begin
               if (stat.mode == MODE_RAND) begin
                  cmd.n_load = 1'b1;
                  cmd.n_val  = CNT_W'(MAX_SLICE);
                  ret_in     = R_SLICE;
                  state_in   = S_BELOW;
               end else begin
                  cmd.op   = OP_FIN_SLICE;
                  state_in = S_OUT;
               end
            end else if (stat.count == '0) begin
               cmd.op   = OP_FIN_EMPTY;
               state_in = S_OUT;
            end else if (stat.mode == MODE_RAND) begin
               cmd.n_load = 1'b1;
               cmd.n_val  = stat.count;
               ret_in     = R_RAND;
               state_in   = S_BELOW;
            end else if (stat.mode == MODE_OLD) begin
               cmd.op   = OP_OSTART;
               state_in = S_OSCAN;
            end else begin
               cmd.op   = OP_FIN_RR;
               state_in = S_OUT;
            end
         end
         // draw below n: zero for n of at most one, else limit, then draws until one is accepted, then reduce
         S_BELOW: begin
            if (stat.n_le1) begin
               cmd.op   = OP_KZERO;
               state_in = S_RET;
            end else begin
               cmd.op   = OP_REM_MAX;
               cnt_in   = '0;
               state_in = S_LREM;
            end
         end
         S_LREM: begin
            cmd.op = OP_REM_STEP;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = S_LIM;
         end
         S_LIM: begin
            cmd.op   = OP_LIM;
            state_in = S_ADV;
         end
         S_ADV: begin
            cmd.op   = OP_ADV;
            cnt_in   = '0;
            state_in = S_M1;
         end
         S_M1: begin
            cmd.op = OP_MUL;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) state_in = S_X2;
         end
         S_X2: begin
            cmd.op   = OP_MIX2;
            cnt_in   = '0;
            state_in = S_M2;
         end
         S_M2: begin
            cmd.op = OP_MUL;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd2) state_in = S_X3;
         end
         S_X3: begin
            cmd.op   = OP_MIX3;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (stat.v_gt_lim) begin
               state_in = S_ADV;
            end else begin
               cmd.op   = OP_REM_V;
               cnt_in   = '0;
               state_in = S_VREM;
            end
         end
         S_VREM: begin
            cmd.op = OP_REM_STEP;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = S_KSET;
         end
         S_KSET: begin
            cmd.op   = OP_KSET;
            state_in = S_RET;
         end
         S_RET: begin
            unique case (ret_ff)
               R_SLICE: begin
                  cmd.op   = OP_FIN_RSLICE;
                  state_in = S_OUT;
               end
               R_RAND: begin
                  cmd.op   = OP_RSTART;
                  state_in = S_RSCAN;
               end
               R_TIE: begin
                  cmd.op   = OP_OTIE;
                  state_in = stat.idx_last ? S_OFIN : S_OSCAN;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RSCAN: begin
            if (stat.kth_hit) begin
               cmd.op   = OP_FIN_RAND;
               state_in = S_OUT;
            end else begin
               cmd.op = OP_RSTEP;
            end
         end
         // ascending scan; a tie calls a one-bit draw before advancing
         S_OSCAN: begin
            if (!stat.bit_on) begin
               cmd.op = OP_ONEXT;
               if (stat.idx_last) state_in = S_OFIN;
            end else if (stat.cand && stat.t_eq) begin
               cmd.op     = OP_OSTEP;
               cmd.n_load = 1'b1;
               cmd.n_val  = CNT_W'(2);
               ret_in     = R_TIE;
               state_in   = S_BELOW;
            end else begin
               cmd.op  = OP_OSTEP;
               cmd.adv = 1'b1;
               if (stat.idx_last) state_in = S_OFIN;
            end
         end
         S_OFIN: begin
            cmd.op   = OP_OFIN;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= R_SLICE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/warp_issue_scheduler_unit.sv =====
// Warp issue scheduler top level. Items are taken one at a time. A round-robin pick,
// a non-random slice or an empty mask goes straight to the result; a draw below n
// computes the limit, then generator draws until one is accepted, then the reduction,
// using the shared 32x32 multiplier and the 4-bit-per-cycle remainder.
// Oldest-first picks scan all 32 warps, one per cycle, plus a draw per tie.
// Synchronous reset restores mode 0, seed 1, slice 1 and clears all history.
module warp_issue_scheduler_unit (
   input logic clock,
   input logic reset,
   wis_req_if.sink   req_chan,
   wis_rsp_if.source rsp_chan,
   wis_csr_if.sink   csr_chan
);
   import wis_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     ctrl_ready;

   wis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wis_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_ready (ctrl_ready),
      .stat      (stat),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_chan  (csr_chan)
   );

   // an empty-mask answer carries no warp and no slice
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.no_runnable |->
         rsp_chan.picked_warp == '0 && rsp_chan.slice_length == '0)
      else $error("empty-mask result carries a payload");

   // a slice answer never names a warp
   a_slice_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.slice_length != '0 |->
         rsp_chan.picked_warp == '0 && !rsp_chan.no_runnable)
      else $error("slice result names a warp");

   // one item in flight: no transfer in the cycle after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && ctrl_ready |=> !ctrl_ready)
      else $error("request taken while busy");

endmodule

// ===== tb/wis_tb_pkg.sv =====
// Item codes shared by the scheduler testbench top and its checker.
// Depends on nothing; the block's own package supplies widths and register codes.
package wis_tb_pkg;

   localparam logic KIND_PICK  = 1'b0;
   localparam logic KIND_SLICE = 1'b1;

endpackage

// ===== tb/wis_checker.sv =====
// Scoreboard for the warp issue scheduler: mirrors its scheduling state, predicts
// each response and compares it. Depends on wis_pkg, wis_tb_pkg and the channel interfaces.
module wis_checker (
   input  logic clock,
   input  logic reset,
   wis_req_if   req,
   wis_rsp_if   rsp,
   wis_csr_if   csr,
   output int   fail_count,
   output int   pending
);
   import wis_pkg::*;
   import wis_tb_pkg::*;

   typedef struct {
      logic [4:0] warp;
      logic [7:0] slice;
      logic       empty;
   } decision_type;

   logic [1:0]  sched_mode;
   logic [63:0] seed_reg;
   logic [7:0]  slice_reg;
   logic [63:0] rng;
   logic [4:0]  prev_warp;
   logic        prev_valid;
   logic [63:0] tick;
   logic [63:0] last_run [WARPS];
   decision_type awaited [$];

   function automatic void clear_history();
      rng        = (seed_reg == 0) ? 64'd1 : seed_reg;
      prev_warp  = '0;
      prev_valid = 1'b0;
      tick       = '0;
      for (int i = 0; i < WARPS; i++) last_run[i] = '0;
   endfunction

   // advance the generator and mix its state
   function automatic logic [63:0] splitmix();
      logic [63:0] z;
      rng = rng + GAMMA;
      z = rng;
      z = (z ^ (z >> 30)) * MIX_C1;
      z = (z ^ (z >> 27)) * MIX_C2;
      return z ^ (z >> 31);
   endfunction

   // unbiased draw below n by rejection
   function automatic logic [63:0] draw_below(input logic [63:0] n);
      logic [63:0] lim, v;
      if (n <= 1) return '0;
      lim = 64'hFFFF_FFFF_FFFF_FFFF - (64'hFFFF_FFFF_FFFF_FFFF % n) - 1;
      do v = splitmix(); while (v > lim);
      return v % n;
   endfunction

   function automatic logic [4:0] next_round_robin(input logic [31:0] m);
      logic [4:0] first;
      logic       seen;
      first = '0;
      seen  = 1'b0;
      for (int i = 0; i < WARPS; i++) begin
         if (!m[i]) continue;
         if (!seen) begin
            first = 5'(i);
            seen  = 1'b1;
         end
         if (prev_valid && i > prev_warp) begin
            prev_warp = 5'(i);
            return 5'(i);
         end
      end
      prev_warp  = first;
      prev_valid = 1'b1;
      return first;
   endfunction

   function automatic logic [4:0] random_warp(input logic [31:0] m, input int cnt);
      logic [63:0] k;
      int          seen;
      k = draw_below(64'(cnt));
      seen = 0;
      for (int i = 0; i < WARPS; i++) begin
         if (!m[i]) continue;
         if (seen == k) return 5'(i);
         seen++;
      end
      return '0;
   endfunction

   function automatic logic [4:0] oldest_warp(input logic [31:0] m, input int cnt);
      int          best;
      logic [63:0] oldest, t;
      best   = WARPS;
      oldest = '1;
      tick   = tick + 1;
      for (int i = 0; i < WARPS; i++) begin
         if (!m[i]) continue;
         if (best == WARPS) best = i;
         // skip the previous warp while anyone else can run
         if (prev_valid && i == prev_warp && cnt > 1) continue;
         t = last_run[i];
         if (t < oldest || (t == oldest && draw_below(64'd2) != 0)) begin
            oldest = t;
            best   = i;
         end
      end
      if (best >= WARPS) best = 0;
      last_run[best] = tick;
      prev_warp  = 5'(best);
      prev_valid = 1'b1;
      return 5'(best);
   endfunction

   function automatic decision_type schedule(input logic kind, input logic [31:0] m);
      decision_type d;
      int           cnt;
      d = '{warp: '0, slice: '0, empty: 1'b0};
      if (kind == KIND_SLICE) begin
         if (sched_mode == MODE_RAND) d.slice = 8'(1 + draw_below(64'(MAX_SLICE)));
         else if (sched_mode == MODE_OLD) d.slice = 8'd1;
         else d.slice = slice_reg;
         return d;
      end
      cnt = $countones(m);
      if (cnt == 0) d.empty = 1'b1;
      else if (sched_mode == MODE_RAND) d.warp = random_warp(m, cnt);
      else if (sched_mode == MODE_OLD) d.warp = oldest_warp(m, cnt);
      else d.warp = next_round_robin(m);
      return d;
   endfunction

   assign pending = awaited.size();

   // track register writes, accepted requests and returned decisions
   always @(posedge clock) begin
      decision_type want;
      if (reset) begin
         sched_mode <= MODE_RR;
         seed_reg = 64'd1;
         slice_reg = 8'd1;
         clear_history();
         awaited.delete();
         fail_count <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_MODE: begin
                  sched_mode <= csr.data[1:0];
                  clear_history();
               end
               REG_SEED: begin
                  seed_reg = csr.data;
                  rng = (seed_reg == 0) ? 64'd1 : seed_reg;
               end
               REG_SLICE: slice_reg = csr.data[7:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) awaited.push_back(schedule(req.kind, req.runnable_mask));
         if (rsp.valid && rsp.ready) begin
            if (awaited.size() == 0) begin
               if (fail_count < 10) $display("wis_checker: response with nothing pending");
               fail_count <= fail_count + 1;
            end else begin
               want = awaited.pop_front();
               if (rsp.picked_warp !== want.warp || rsp.slice_length !== want.slice ||
                   rsp.no_runnable !== want.empty) begin
                  if (fail_count < 10)
                     $display("wis_checker: exp warp %0d slice %0d empty %0d, got %0d %0d %0d",
                              want.warp, want.slice, want.empty, rsp.picked_warp,
                              rsp.slice_length, rsp.no_runnable);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb_warp_issue_scheduler_unit.sv =====
// Testbench top for warp_issue_scheduler_unit: drives requests, register writes and
// response back-pressure, and reports the verdict. Depends on wis_pkg, wis_tb_pkg, wis_checker.
module tb_warp_issue_scheduler_unit;
   import wis_pkg::*;
   import wis_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   logic long_hold = 1'b0;
   int   fail_count;
   int   pending;

   wis_req_if req_chan ();
   wis_rsp_if rsp_chan ();
   wis_csr_if csr_chan ();

   warp_issue_scheduler_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   wis_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr        (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #2 clock = ~clock;

   initial begin
      #40_000_000;
      $display("tb_warp_issue_scheduler_unit: FAIL");
      $finish;
   end

   // response back-pressure: random stall bursts, one long hold on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold <= 1'b0;
            @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   // offer one request, hold until the transfer, then maybe leave a gap
   task automatic send(input logic kind, input logic [31:0] m);
      req_chan.valid         <= 1'b1;
      req_chan.kind          <= kind;
      req_chan.runnable_mask <= m;
      do @(posedge clock); while (!req_chan.ready);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] any_mask();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'd1 << $urandom_range(0, 31);
         2: return '0;
         3: return '1;
         4: return $urandom & $urandom & $urandom;
         default: return 32'($urandom_range(0, 255)) << $urandom_range(0, 24);
      endcase
   endfunction

   task automatic run_phase(input logic [1:0] mode, input logic [63:0] seed,
                            input logic [7:0] slice, input int items, input bit directed);
      write_reg(REG_SLICE, slice);
      write_reg(REG_SEED, seed);
      write_reg(REG_MODE, mode);
      if (directed) begin
         send(KIND_PICK, 32'h0);
         send(KIND_PICK, 32'hFFFF_FFFF);
         send(KIND_PICK, 32'h0000_0001);
         send(KIND_PICK, 32'h8000_0000);
         send(KIND_PICK, 32'h8000_0000);
         send(KIND_PICK, 32'h0000_0005);
         send(KIND_PICK, 32'h0000_0005);
         send(KIND_SLICE, 32'hFFFF_FFFF);
         send(KIND_SLICE, 32'h0);
      end
      for (int i = 0; i < items; i++)
         send(($urandom_range(0, 3) == 0) ? KIND_SLICE : KIND_PICK, any_mask());
      drain();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_PICK;
      req_chan.runnable_mask = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = REG_MODE;
      csr_chan.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults first, then every mode and register extreme
      for (int i = 0; i < 10; i++) send(($urandom_range(0, 1) == 0) ? KIND_SLICE : KIND_PICK, any_mask());
      drain();
      run_phase(MODE_RR, 64'd1, 8'd0, 170, 1'b1);
      run_phase(MODE_RAND, 64'd0, 8'd1, 170, 1'b1);
      run_phase(MODE_OLD, $urandom, 8'd9, 170, 1'b1);
      run_phase(2'd3, 64'd5, 8'd255, 150, 1'b0);
      fork
         run_phase(MODE_RAND, '1, 8'd7, 180, 1'b0);
         begin
            repeat (200) @(posedge clock);
            long_hold <= 1'b1;
         end
      join
      run_phase(MODE_OLD, {$urandom, $urandom}, 8'd1, 170, 1'b0);
      calm <= 1'b1;
      run_phase(MODE_RAND, {$urandom, $urandom}, 8'd128, 200, 1'b0);

      if (fail_count == 0) begin
         $display("tb_warp_issue_scheduler_unit: PASS");
      end else begin
         $display("tb_warp_issue_scheduler_unit: FAIL");
      end
      $finish;
   end

endmodule
